### sv/rsvi_pkg.sv
// Shared types and constants for the ray/slab volume intersect block.
// No dependencies; used by every other file of the block.
package rsvi_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAR_TOL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BND_TOL = 1'd1;

    // Sequencer lengths
    localparam int CNT_W     = 4;
    localparam int MAC_STEPS = 6;   // three n.d products, then three n.o products
    localparam int DIV_STEPS = 16;  // two quotient bits per step

    // Interval reset values
    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC,
        S_CHECK,
        S_DIV_LOAD,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_DONE,
        S_FOLD,
        S_WRAP,
        S_FINISH
    } t_state;

    // Divider strobes
    typedef struct packed {
        logic load;
        logic init;
        logic step;
    } t_div_ctl;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       mac_en;
        logic [2:0] mac_step;
        logic       chk_fold;
        t_div_ctl   div;
        logic       div_sel;    // 0: near plane, 1: far plane
        logic       store_ta;
        logic       store_tb;
        logic       fold;
        logic       emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic missed;
        logic last;
        logic parallel;
        logic out_free;
    } t_sts;

endpackage

### sv/rsvi_div.sv
// Iterative signed divider, two quotient bits per step, saturating to 32 bits.
// Depends on rsvi_pkg for the strobe struct.
module rsvi_div (
    input  logic                  i_clk,
    input  rsvi_pkg::t_div_ctl    i_ctl,
    input  logic signed [48:0]    i_num,
    input  logic signed [33:0]    i_den,
    output logic signed [31:0]    o_quot
);

    logic [61:0] r_num;
    logic [31:0] r_den;
    logic        r_neg;
    logic        r_ovf;
    logic [31:0] r_rem;
    logic [31:0] r_low;
    logic [31:0] r_q;

    logic [47:0] num_mag;
    logic [33:0] den_abs;
    logic [32:0] s1;
    logic [32:0] s2;
    logic [31:0] rem1;
    logic [31:0] rem2;
    logic        q1;
    logic        q2;

    // Magnitudes of the operands
    always_comb begin
        num_mag = i_num[48] ? 48'(-i_num) : i_num[47:0];
        den_abs = i_den[33] ? 34'(-i_den) : 34'(i_den);
    end

    // Two restoring steps per cycle while the step strobe is high
    always_comb begin
        s1 = {r_rem, r_low[31]};
        if (s1 >= {1'b0, r_den}) begin
            q1   = 1'b1;
            rem1 = 32'(s1 - {1'b0, r_den});
        end else begin
            q1   = 1'b0;
            rem1 = s1[31:0];
        end
        s2 = {rem1, r_low[30]};
        if (s2 >= {1'b0, r_den}) begin
            q2   = 1'b1;
            rem2 = 32'(s2 - {1'b0, r_den});
        end else begin
            q2   = 1'b0;
            rem2 = s2[31:0];
        end
    end

    // Load operands, test for overflow, then iterate
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_num <= {num_mag, 14'b0};
            r_den <= den_abs[31:0];
            r_neg <= i_num[48] ^ i_den[33];
        end
        if (i_ctl.init) begin
            r_ovf <= {1'b0, r_num} >= {r_den, 31'b0};
            r_rem <= {2'b0, r_num[61:32]};
            r_low <= r_num[31:0];
            r_q   <= '0;
        end
        if (i_ctl.step) begin
            r_rem <= rem2;
            r_low <= {r_low[29:0], 2'b00};
            r_q   <= {r_q[29:0], q1, q2};
        end
    end

    // Apply sign; saturate when the quotient magnitude reaches 2^31
    always_comb begin
        if (r_ovf) begin
            o_quot = r_neg ? rsvi_pkg::T_MIN : rsvi_pkg::T_MAX;
        end else if (r_neg) begin
            o_quot = -$signed(r_q);
        end else begin
            o_quot = $signed(r_q);
        end
    end

endmodule

### sv/rsvi_ctrl.sv
// Controller of the slab test: sequences dot products, divisions and folding.
// Depends on rsvi_pkg for state, command and status types.
module rsvi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rsvi_pkg::t_sts i_sts,
    output rsvi_pkg::t_cmd o_cmd
);

    rsvi_pkg::t_state r_state, n_state;
    logic [rsvi_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic r_sel, n_sel;

    localparam logic [rsvi_pkg::CNT_W-1:0] MAC_LAST = rsvi_pkg::CNT_W'(rsvi_pkg::MAC_STEPS - 1);
    localparam logic [rsvi_pkg::CNT_W-1:0] DIV_LAST = rsvi_pkg::CNT_W'(rsvi_pkg::DIV_STEPS - 1);

    // State, step counter and plane select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsvi_pkg::S_IDLE;
            r_cnt   <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        case (r_state)
            rsvi_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.missed ? rsvi_pkg::S_WRAP : rsvi_pkg::S_MAC;
                    n_cnt   = '0;
                end
            end
            rsvi_pkg::S_MAC: begin
                if (r_cnt == MAC_LAST) begin
                    n_state = rsvi_pkg::S_CHECK;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            rsvi_pkg::S_CHECK: begin
                n_sel   = 1'b0;
                n_state = i_sts.parallel ? rsvi_pkg::S_WRAP : rsvi_pkg::S_DIV_LOAD;
            end
            rsvi_pkg::S_DIV_LOAD: begin
                n_state = rsvi_pkg::S_DIV_INIT;
            end
            rsvi_pkg::S_DIV_INIT: begin
                n_state = rsvi_pkg::S_DIV_STEP;
                n_cnt   = '0;
            end
            rsvi_pkg::S_DIV_STEP: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = rsvi_pkg::S_DIV_DONE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            rsvi_pkg::S_DIV_DONE: begin
                if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = rsvi_pkg::S_DIV_LOAD;
                end else begin
                    n_state = rsvi_pkg::S_FOLD;
                end
            end
            rsvi_pkg::S_FOLD: begin
                n_state = rsvi_pkg::S_WRAP;
            end
            rsvi_pkg::S_WRAP: begin
                n_state = i_sts.last ? rsvi_pkg::S_FINISH : rsvi_pkg::S_IDLE;
            end
            rsvi_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = rsvi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rsvi_pkg::S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd          = '0;
        o_in_stall     = (r_state != rsvi_pkg::S_IDLE);
        o_cmd.mac_step = r_cnt[2:0];
        o_cmd.div_sel  = r_sel;
        case (r_state)
            rsvi_pkg::S_IDLE:     o_cmd.load     = i_in_valid;
            rsvi_pkg::S_MAC:      o_cmd.mac_en   = 1'b1;
            rsvi_pkg::S_CHECK:    o_cmd.chk_fold = i_sts.parallel;
            rsvi_pkg::S_DIV_LOAD: o_cmd.div.load = 1'b1;
            rsvi_pkg::S_DIV_INIT: o_cmd.div.init = 1'b1;
            rsvi_pkg::S_DIV_STEP: o_cmd.div.step = 1'b1;
            rsvi_pkg::S_DIV_DONE: begin
                o_cmd.store_ta = !r_sel;
                o_cmd.store_tb = r_sel;
            end
            rsvi_pkg::S_FOLD:     o_cmd.fold     = 1'b1;
            rsvi_pkg::S_FINISH:   o_cmd.emit     = i_sts.out_free;
            default: begin
            end
        endcase
    end

endmodule

### sv/rsvi_dp.sv
// Datapath of the slab test: item registers, dot-product MAC, interval state, result.
// Depends on rsvi_pkg and instantiates rsvi_div.
module rsvi_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rsvi_pkg::t_cmd       i_cmd,
    output rsvi_pkg::t_sts       o_sts,
    input  logic                 i_cfg_we,
    input  logic [rsvi_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic signed [31:0]   i_origin_x,
    input  logic signed [31:0]   i_origin_y,
    input  logic signed [31:0]   i_origin_z,
    input  logic signed [15:0]   i_dir_x,
    input  logic signed [15:0]   i_dir_y,
    input  logic signed [15:0]   i_dir_z,
    input  logic signed [15:0]   i_normal_x,
    input  logic signed [15:0]   i_normal_y,
    input  logic signed [15:0]   i_normal_z,
    input  logic signed [31:0]   i_slab_near,
    input  logic signed [31:0]   i_slab_far,
    input  logic                 i_last_slab,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic                 o_hit,
    output logic [30:0]          o_distance
);

    // Configuration
    logic [13:0] r_ptol;
    logic [15:0] r_btol;

    // Item registers
    logic signed [31:0] r_org [3];
    logic signed [15:0] r_dir [3];
    logic signed [15:0] r_nrm [3];
    logic signed [31:0] r_near;
    logic signed [31:0] r_far;
    logic               r_last;

    // Dot products
    logic signed [49:0] r_acc, n_acc;
    logic signed [33:0] r_nd;
    logic [1:0]         mac_idx;
    logic signed [15:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [47:0] prod;

    // Interval and result
    logic signed [31:0] r_ta;
    logic signed [31:0] r_tb;
    logic signed [31:0] r_entry;
    logic signed [31:0] r_exit;
    logic               r_missed;
    logic               r_out_valid;
    logic               r_hit;
    logic [30:0]        r_dist;

    logic signed [45:0] near_w;
    logic signed [45:0] far_w;
    logic signed [50:0] no_x;
    logic signed [50:0] lo_bound;
    logic signed [50:0] hi_bound;
    logic signed [50:0] diff;
    logic [33:0]        nd_mag;
    logic               org_between;
    logic signed [31:0] quot;
    logic signed [31:0] t_lo;
    logic signed [31:0] t_hi;
    logic signed [31:0] new_entry;
    logic signed [31:0] new_exit;
    logic signed [31:0] t_clamp;
    logic               res_hit;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptol <= 14'd1;
            r_btol <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rsvi_pkg::CFG_PAR_TOL: r_ptol <= i_cfg_data[13:0];
                rsvi_pkg::CFG_BND_TOL: r_btol <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Latch the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_org[0] <= i_origin_x;
            r_org[1] <= i_origin_y;
            r_org[2] <= i_origin_z;
            r_dir[0] <= i_dir_x;
            r_dir[1] <= i_dir_y;
            r_dir[2] <= i_dir_z;
            r_nrm[0] <= i_normal_x;
            r_nrm[1] <= i_normal_y;
            r_nrm[2] <= i_normal_z;
            r_near   <= i_slab_near;
            r_far    <= i_slab_far;
            r_last   <= i_last_slab;
        end
    end

    // Select MAC operands: n.d for steps 0..2, n.o for steps 3..5
    always_comb begin
        if (i_cmd.mac_step < 3'd3) begin
            mac_idx = i_cmd.mac_step[1:0];
            mul_b   = 32'(r_dir[mac_idx]);
        end else begin
            mac_idx = 2'(i_cmd.mac_step - 3'd3);
            mul_b   = r_org[mac_idx];
        end
        mul_a = r_nrm[mac_idx];
        prod  = mul_a * mul_b;
        if (i_cmd.mac_step == 3'd0 || i_cmd.mac_step == 3'd3) begin
            n_acc = 50'(prod);
        end else begin
            n_acc = r_acc + 50'(prod);
        end
    end

    // Accumulate; keep n.d once its three terms are in
    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_en) begin
            r_acc <= n_acc;
            if (i_cmd.mac_step == 3'd3) begin
                r_nd <= r_acc[33:0];
            end
        end
    end

    // Parallel and inside tests, and the division numerator
    always_comb begin
        near_w      = $signed({r_near, 14'b0});
        far_w       = $signed({r_far, 14'b0});
        no_x        = 51'(r_acc);
        lo_bound    = 51'(near_w) - $signed({21'b0, r_btol, 14'b0});
        hi_bound    = 51'(far_w) + $signed({21'b0, r_btol, 14'b0});
        org_between = (no_x >= lo_bound) && (no_x <= hi_bound);
        nd_mag      = r_nd[33] ? 34'(-r_nd) : 34'(r_nd);
        diff        = (i_cmd.div_sel ? 51'(far_w) : 51'(near_w)) - no_x;
    end

    rsvi_div u_div (
        .i_clk  (i_clk),
        .i_ctl  (i_cmd.div),
        .i_num  (diff[48:0]),
        .i_den  (r_nd),
        .o_quot (quot)
    );

    // Hold both plane parameters
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_ta) begin
            r_ta <= quot;
        end
        if (i_cmd.store_tb) begin
            r_tb <= quot;
        end
    end

    // Order the parameters and narrow the interval
    always_comb begin
        t_lo      = (r_ta > r_tb) ? r_tb : r_ta;
        t_hi      = (r_ta > r_tb) ? r_ta : r_tb;
        new_entry = (t_lo > r_entry) ? t_lo : r_entry;
        new_exit  = (t_hi < r_exit) ? t_hi : r_exit;
        t_clamp   = r_entry[31] ? 32'sd0 : r_entry;
        res_hit   = !r_missed && (t_clamp <= r_exit);
    end

    // Interval state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry  <= rsvi_pkg::T_MIN;
            r_exit   <= rsvi_pkg::T_MAX;
            r_missed <= 1'b0;
        end else if (i_cmd.emit) begin
            r_entry  <= rsvi_pkg::T_MIN;
            r_exit   <= rsvi_pkg::T_MAX;
            r_missed <= 1'b0;
        end else if (i_cmd.fold) begin
            r_entry <= new_entry;
            r_exit  <= new_exit;
            if (new_entry > new_exit) begin
                r_missed <= 1'b1;
            end
        end else if (i_cmd.chk_fold && !org_between) begin
            r_missed <= 1'b1;
        end
    end

    // Result register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_hit  <= res_hit;
            r_dist <= res_hit ? t_clamp[30:0] : 31'd0;
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.missed   = r_missed;
        o_sts.last     = r_last;
        o_sts.parallel = (r_nd == 34'sd0) || (nd_mag < {6'b0, r_ptol, 14'b0});
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_distance  = r_dist;

endmodule

### sv/ray_slab_volume_intersect.sv
// Top level of the ray versus slab-bounded volume test.
// Depends on rsvi_pkg; instantiates rsvi_ctrl and rsvi_dp.
//
//   channel   handshake                       payload
//   input     i_in_valid / o_in_stall         origin, dir, normal, slab planes, last
//   output    o_out_valid / i_out_stall       hit, distance
//   config    i_cfg_we                        i_cfg_idx, i_cfg_data
//
// A slab is finished before the next is accepted: the single multiply-accumulate
// unit forms both dot products, then two divisions run on the shared radix-4
// divider, followed by fold and wrap-up. A parallel slab skips the divisions and the
// fold, and a slab after a miss goes straight to wrap-up. A last slab adds a finish
// step that loads the result once the output is free. Reset is synchronous and
// active low. A stalled result is held in the output register; the next item is
// still accepted, and only the next result waits for it to be taken.
module ray_slab_volume_intersect (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [rsvi_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [31:0]   i_origin_x,
    input  logic signed [31:0]   i_origin_y,
    input  logic signed [31:0]   i_origin_z,
    input  logic signed [15:0]   i_dir_x,
    input  logic signed [15:0]   i_dir_y,
    input  logic signed [15:0]   i_dir_z,
    input  logic signed [15:0]   i_normal_x,
    input  logic signed [15:0]   i_normal_y,
    input  logic signed [15:0]   i_normal_z,
    input  logic signed [31:0]   i_slab_near,
    input  logic signed [31:0]   i_slab_far,
    input  logic                 i_last_slab,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_hit,
    output logic [30:0]          o_distance
);

    rsvi_pkg::t_cmd cmd;
    rsvi_pkg::t_sts sts;

    rsvi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rsvi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_origin_x  (i_origin_x),
        .i_origin_y  (i_origin_y),
        .i_origin_z  (i_origin_z),
        .i_dir_x     (i_dir_x),
        .i_dir_y     (i_dir_y),
        .i_dir_z     (i_dir_z),
        .i_normal_x  (i_normal_x),
        .i_normal_y  (i_normal_y),
        .i_normal_z  (i_normal_z),
        .i_slab_near (i_slab_near),
        .i_slab_far  (i_slab_far),
        .i_last_slab (i_last_slab),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_hit       (o_hit),
        .o_distance  (o_distance)
    );

endmodule
